>>> hw/rtl/hat_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hilbert transpose converter package
// Shared constants, register map and the control struct for one bit level.
// ---------------------------------------------------------------------------
package hat_pkg;

   localparam int NUM_FIELDS         = 4;
   localparam int FIELD_W            = 16;
   localparam int MAX_DIMS_DEFAULT   = 4;
   localparam int COORD_BITS_DEFAULT = 16;

   localparam int DIMS_W     = 3;
   localparam int BITS_W     = 5;
   localparam int LANE_CNT_W = 3;
   localparam int BIT_IDX_W  = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_DIRECTION   = 2'd0,
      REG_DIMS_IN_USE = 2'd1,
      REG_BITS_IN_USE = 2'd2
   } reg_index_type;

   localparam logic DIR_TO_TRANSPOSE = 1'b0;
   localparam logic DIR_TO_AXES      = 1'b1;

   localparam logic              DIRECTION_RESET   = DIR_TO_TRANSPOSE;
   localparam logic [DIMS_W-1:0] DIMS_IN_USE_RESET = 3'd3;
   localparam logic [BITS_W-1:0] BITS_IN_USE_RESET = 5'd16;

   // Control for one bit level of the exchange and inversion sweep.
   typedef struct packed {
      logic                  to_axes;
      logic                  active;
      logic [LANE_CNT_W-1:0] lanes;
      logic [BIT_IDX_W-1:0]  bit_idx;
   } step_ctl_type;

endpackage

>>> hw/rtl/hat_bit_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hilbert transpose converter, one bit level
// Applies the exchange or inversion rule of one bit level to the lanes in use,
// in ascending lane order toward the transpose and descending toward axes.
// ---------------------------------------------------------------------------
module hat_bit_step #(
   parameter int LANES = hat_pkg::NUM_FIELDS,
   parameter int WIDTH = hat_pkg::COORD_BITS_DEFAULT
) (
   input  hat_pkg::step_ctl_type         ctl,
   input  logic [LANES-1:0][WIDTH-1:0]   lanes_i,
   output logic [LANES-1:0][WIDTH-1:0]   lanes_o
);

   logic [WIDTH-1:0]             low_mask;
   logic [WIDTH-1:0]             bit_sel;
   logic [LANES-1:0][WIDTH-1:0]  fwd_v;
   logic [LANES-1:0][WIDTH-1:0]  rev_v;
   logic [LANES-1:0][WIDTH-1:0]  swap_f;
   logic [LANES-1:0][WIDTH-1:0]  swap_r;

   always_comb begin
      for (int j = 0; j < WIDTH; j++) begin
         low_mask[j] = (j < int'(ctl.bit_idx));
         bit_sel[j]  = (j == int'(ctl.bit_idx));
      end
   end

   // When the lane has the bit set, lane 0 inverts its low bits; otherwise
   // the low bits of lane 0 and this lane are exchanged.
   always_comb begin
      fwd_v = lanes_i;
      for (int i = 0; i < LANES; i++) begin
         swap_f[i] = '0;
         if (i < int'(ctl.lanes)) begin
            if (|(fwd_v[i] & bit_sel)) begin
               fwd_v[0] = fwd_v[0] ^ low_mask;
            end else begin
               swap_f[i] = (fwd_v[0] ^ fwd_v[i]) & low_mask;
               fwd_v[0]  = fwd_v[0] ^ swap_f[i];
               fwd_v[i]  = fwd_v[i] ^ swap_f[i];
            end
         end
      end
   end

   always_comb begin
      rev_v = lanes_i;
      for (int i = LANES - 1; i >= 0; i--) begin
         swap_r[i] = '0;
         if (i < int'(ctl.lanes)) begin
            if (|(rev_v[i] & bit_sel)) begin
               rev_v[0] = rev_v[0] ^ low_mask;
            end else begin
               swap_r[i] = (rev_v[0] ^ rev_v[i]) & low_mask;
               rev_v[0]  = rev_v[0] ^ swap_r[i];
               rev_v[i]  = rev_v[i] ^ swap_r[i];
            end
         end
      end
   end

   always_comb begin
      if (!ctl.active) begin
         lanes_o = lanes_i;
      end else if (ctl.to_axes == hat_pkg::DIR_TO_AXES) begin
         lanes_o = rev_v;
      end else begin
         lanes_o = fwd_v;
      end
   end

endmodule

>>> hw/rtl/hilbert_axes_transpose_convert_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hilbert axes / transpose converter
// Converts one point of up to four coordinates per transaction between
// geometric axes and the Hilbert transpose form.
// ---------------------------------------------------------------------------
// Stages from request to response: one input stage, one stage per bit level
// above bit zero, and one Gray / output stage.
// One transaction per cycle while rsp_ready allows; each bit level is a stage.
// Reset clears all stage valid bits and the response valid, and loads the
// registers with direction 0, dims_in_use 3 and bits_in_use 16.
// ---------------------------------------------------------------------------
module hilbert_axes_transpose_convert_top #(
   parameter int MAX_DIMS   = hat_pkg::MAX_DIMS_DEFAULT,
   parameter int COORD_BITS = hat_pkg::COORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hat_pkg::FIELD_W-1:0]      req_coord_0,
   input  logic [hat_pkg::FIELD_W-1:0]      req_coord_1,
   input  logic [hat_pkg::FIELD_W-1:0]      req_coord_2,
   input  logic [hat_pkg::FIELD_W-1:0]      req_coord_3,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hat_pkg::FIELD_W-1:0]      rsp_word_0,
   output logic [hat_pkg::FIELD_W-1:0]      rsp_word_1,
   output logic [hat_pkg::FIELD_W-1:0]      rsp_word_2,
   output logic [hat_pkg::FIELD_W-1:0]      rsp_word_3,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hat_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hat_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hat_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int LANES = (MAX_DIMS < hat_pkg::NUM_FIELDS) ? MAX_DIMS : hat_pkg::NUM_FIELDS;
   localparam int W     = COORD_BITS;
   localparam int BW    = $clog2(W + 1);
   localparam int NF    = hat_pkg::NUM_FIELDS;
   localparam int FW    = hat_pkg::FIELD_W;

   // Configuration registers.
   logic                           dir_ff,  dir_in;
   logic [hat_pkg::DIMS_W-1:0]     dims_ff, dims_in;
   logic [hat_pkg::BITS_W-1:0]     bits_ff, bits_in;
   logic                           csr_wr;

   logic [hat_pkg::LANE_CNT_W-1:0] lanes_eff;
   logic [BW-1:0]                  bits_eff;
   logic [W-1:0]                   coord_mask;

   // Pipeline.
   logic [NF-1:0][FW-1:0]          req_words;
   logic [LANES-1:0][W-1:0]        pre_v;
   logic [W-1:0]                   pre_last;
   logic [LANES-1:0][W-1:0]        stage0_in;
   logic [LANES-1:0][W-1:0]        data_ff  [W];
   logic [LANES-1:0][W-1:0]        step_out [W-1];
   logic [W-1:0]                   vld_ff;
   logic [W-1:0]                   stage_en;
   logic                           out_en;

   logic [LANES-1:0][W-1:0]        gray_v;
   logic [W-1:0]                   gray_last;
   logic [W-1:0]                   excess;
   logic                           parity;
   logic [NF-1:0][FW-1:0]          post_in;
   logic [NF-1:0][FW-1:0]          word_ff;
   logic                           rsp_valid_ff;

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      dir_in  = dir_ff;
      dims_in = dims_ff;
      bits_in = bits_ff;
      if (csr_wr) begin
         case (hat_pkg::reg_index_type'(csr_paddr[3:2]))
            hat_pkg::REG_DIRECTION:   dir_in  = csr_pwdata[0];
            hat_pkg::REG_DIMS_IN_USE: dims_in = csr_pwdata[hat_pkg::DIMS_W-1:0];
            hat_pkg::REG_BITS_IN_USE: bits_in = csr_pwdata[hat_pkg::BITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (hat_pkg::reg_index_type'(csr_paddr[3:2]))
         hat_pkg::REG_DIRECTION:   csr_prdata = hat_pkg::CSR_DATA_W'(dir_ff);
         hat_pkg::REG_DIMS_IN_USE: csr_prdata = hat_pkg::CSR_DATA_W'(dims_ff);
         hat_pkg::REG_BITS_IN_USE: csr_prdata = hat_pkg::CSR_DATA_W'(bits_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= hat_pkg::DIRECTION_RESET;
         dims_ff <= hat_pkg::DIMS_IN_USE_RESET;
         bits_ff <= hat_pkg::BITS_IN_USE_RESET;
      end else begin
         dir_ff  <= dir_in;
         dims_ff <= dims_in;
         bits_ff <= bits_in;
      end
   end

   // Out-of-range counts saturate; a count of zero acts as one.
   always_comb begin
      if (dims_ff == '0) begin
         lanes_eff = hat_pkg::LANE_CNT_W'(1);
      end else if (int'(dims_ff) > LANES) begin
         lanes_eff = hat_pkg::LANE_CNT_W'(LANES);
      end else begin
         lanes_eff = hat_pkg::LANE_CNT_W'(dims_ff);
      end

      if (bits_ff == '0) begin
         bits_eff = BW'(1);
      end else if (int'(bits_ff) > W) begin
         bits_eff = BW'(W);
      end else begin
         bits_eff = BW'(bits_ff);
      end

      for (int j = 0; j < W; j++) begin
         coord_mask[j] = (j < int'(bits_eff));
      end
   end

   // ------------------------------------------------------------------
   // Handshake: a stage loads when it is empty or the next one loads.
   // ------------------------------------------------------------------
   assign out_en = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stage_en[W-1] = !vld_ff[W-1] || out_en;
      for (int s = W - 2; s >= 0; s--) begin
         stage_en[s] = !vld_ff[s] || stage_en[s+1];
      end
   end

   assign req_ready = stage_en[0];

   // ------------------------------------------------------------------
   // Input stage: masking, and the Gray decode toward axes.
   // ------------------------------------------------------------------
   assign req_words = {req_coord_3, req_coord_2, req_coord_1, req_coord_0};

   always_comb begin
      pre_last = '0;
      for (int i = 0; i < LANES; i++) begin
         if (i < int'(lanes_eff)) begin
            pre_v[i] = W'(req_words[i]) & coord_mask;
         end else begin
            pre_v[i] = '0;
         end
         if (i == int'(lanes_eff) - 1) begin
            pre_last = pre_v[i];
         end
      end

      stage0_in = pre_v;
      if (dir_ff == hat_pkg::DIR_TO_AXES) begin
         for (int i = 1; i < LANES; i++) begin
            if (i < int'(lanes_eff)) begin
               stage0_in[i] = pre_v[i] ^ pre_v[i-1];
            end
         end
         stage0_in[0] = pre_v[0] ^ (pre_last >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int s = 1; s < W; s++) begin
            if (stage_en[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         data_ff[0] <= stage0_in;
      end
   end

   // ------------------------------------------------------------------
   // Bit level stages. Toward the transpose they run from the top bit
   // down; toward axes from bit one up. Levels at or above the bit
   // count pass the data through.
   // ------------------------------------------------------------------
   for (genvar s = 0; s < W - 1; s++) begin : g_level
      hat_pkg::step_ctl_type ctl;

      always_comb begin
         ctl.to_axes = dir_ff;
         ctl.lanes   = lanes_eff;
         if (dir_ff == hat_pkg::DIR_TO_AXES) begin
            ctl.bit_idx = hat_pkg::BIT_IDX_W'(s + 1);
         end else begin
            ctl.bit_idx = hat_pkg::BIT_IDX_W'(W - 1 - s);
         end
         ctl.active = (int'(ctl.bit_idx) < int'(bits_eff));
      end

      hat_bit_step #(
         .LANES (LANES),
         .WIDTH (W)
      ) u_step (
         .ctl     (ctl),
         .lanes_i (data_ff[s]),
         .lanes_o (step_out[s])
      );

      always_ff @(posedge clock) begin
         if (stage_en[s+1]) begin
            data_ff[s+1] <= step_out[s];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: Gray encode and excess fix toward the transpose.
   // ------------------------------------------------------------------
   always_comb begin
      gray_v    = data_ff[W-1];
      gray_last = '0;
      for (int i = 1; i < LANES; i++) begin
         if (i < int'(lanes_eff)) begin
            gray_v[i] = gray_v[i] ^ gray_v[i-1];
         end
      end
      for (int i = 0; i < LANES; i++) begin
         if (i == int'(lanes_eff) - 1) begin
            gray_last = gray_v[i];
         end
      end

      // Each excess bit is the parity of the last word's bits above it.
      parity = 1'b0;
      for (int j = W - 1; j >= 0; j--) begin
         excess[j] = parity;
         parity    = parity ^ gray_last[j];
      end

      post_in = '0;
      for (int i = 0; i < LANES; i++) begin
         if (i < int'(lanes_eff)) begin
            if (dir_ff == hat_pkg::DIR_TO_AXES) begin
               post_in[i] = FW'(data_ff[W-1][i] & coord_mask);
            end else begin
               post_in[i] = FW'((gray_v[i] ^ excess) & coord_mask);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= vld_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && vld_ff[W-1]) begin
         word_ff <= post_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word_0 = word_ff[0];
   assign rsp_word_1 = word_ff[1];
   assign rsp_word_2 = word_ff[2];
   assign rsp_word_3 = word_ff[3];

endmodule

>>> tb/sv/tb_hilbert_axes_transpose_convert_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the Hilbert axes / transpose converter
// Drives points through the request channel under several register settings,
// predicts every converted point in both directions and checks the responses
// in order, with random gaps on both sides and one long response hold-off.
// ---------------------------------------------------------------------------
module tb_hilbert_axes_transpose_convert_top;

   localparam int NF = hat_pkg::NUM_FIELDS;
   localparam int FW = hat_pkg::FIELD_W;

   typedef logic [NF-1:0][FW-1:0] point_type;

   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int         DRAIN_CYCLES    = 24;
   localparam int         HOLD_CYCLES     = 160;
   localparam int         STALL_LIMIT     = 3000;
   localparam int         REPORT_LIMIT    = 10;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [FW-1:0]                    req_coord_0 = '0;
   logic [FW-1:0]                    req_coord_1 = '0;
   logic [FW-1:0]                    req_coord_2 = '0;
   logic [FW-1:0]                    req_coord_3 = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [FW-1:0]                    rsp_word_0;
   logic [FW-1:0]                    rsp_word_1;
   logic [FW-1:0]                    rsp_word_2;
   logic [FW-1:0]                    rsp_word_3;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [hat_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [hat_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [hat_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   // Local copy of the register file used by the predictor.
   logic                       dir_sel  = hat_pkg::DIRECTION_RESET;
   logic [hat_pkg::DIMS_W-1:0] dims_reg = hat_pkg::DIMS_IN_USE_RESET;
   logic [hat_pkg::BITS_W-1:0] bits_reg = hat_pkg::BITS_IN_USE_RESET;

   point_type pending_words[$];
   int        mismatches      = 0;
   int        points_sent     = 0;
   int        results_checked = 0;
   int        csr_writes      = 0;
   int        idle_cycles     = 0;
   bit        tx_gaps         = 1'b0;
   bit        rx_gaps         = 1'b0;
   bit        hold_request    = 1'b0;

   hilbert_axes_transpose_convert_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_coord_0 (req_coord_0),
      .req_coord_1 (req_coord_1),
      .req_coord_2 (req_coord_2),
      .req_coord_3 (req_coord_3),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word_0  (rsp_word_0),
      .rsp_word_1  (rsp_word_1),
      .rsp_word_2  (rsp_word_2),
      .rsp_word_3  (rsp_word_3),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short pauses with an occasional long one.
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // Expected converted point for the current register settings.
   function automatic point_type convert_point(input point_type coords);
      int unsigned v[NF];
      int unsigned n, b, mask, top, lim, q, p, t;
      point_type   words;
      n = dims_reg;
      b = bits_reg;
      if (n < 1) n = 1;
      if (n > hat_pkg::MAX_DIMS_DEFAULT) n = hat_pkg::MAX_DIMS_DEFAULT;
      if (n > NF) n = NF;
      if (b < 1) b = 1;
      if (b > hat_pkg::COORD_BITS_DEFAULT) b = hat_pkg::COORD_BITS_DEFAULT;
      mask = (32'd1 << b) - 1;
      for (int i = 0; i < NF; i++) v[i] = (i < n) ? (coords[i] & mask) : 0;
      if (dir_sel == hat_pkg::DIR_TO_AXES) begin
         // Gray decode first, then undo the excess work from the low bit up.
         lim = 32'd2 << (b - 1);
         t = v[n-1] >> 1;
         for (int i = int'(n) - 1; i > 0; i--) v[i] ^= v[i-1];
         v[0] ^= t;
         for (q = 2; q < lim; q <<= 1) begin
            p = q - 1;
            for (int i = int'(n) - 1; i >= 0; i--) begin
               if (v[i] & q) begin
                  v[0] ^= p;
               end else begin
                  t = (v[0] ^ v[i]) & p;
                  v[0] ^= t;
                  v[i] ^= t;
               end
            end
         end
      end else begin
         top = 32'd1 << (b - 1);
         for (q = top; q > 1; q >>= 1) begin
            p = q - 1;
            for (int i = 0; i < n; i++) begin
               if (v[i] & q) begin
                  v[0] ^= p;
               end else begin
                  t = (v[0] ^ v[i]) & p;
                  v[0] ^= t;
                  v[i] ^= t;
               end
            end
         end
         for (int i = 1; i < n; i++) v[i] ^= v[i-1];
         t = 0;
         for (q = top; q > 1; q >>= 1)
            if (v[n-1] & q) t ^= q - 1;
         for (int i = 0; i < n; i++) v[i] ^= t;
      end
      for (int i = 0; i < NF; i++) words[i] = (i < n) ? FW'(v[i] & mask) : '0;
      return words;
   endfunction

   // Predicts on every accepted request and checks every accepted response.
   always @(posedge clock) begin : scoreboard
      point_type got;
      point_type want;
      bit        bad;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_words.push_back(convert_point({req_coord_3, req_coord_2,
                                                   req_coord_1, req_coord_0}));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_word_3, rsp_word_2, rsp_word_1, rsp_word_0};
            results_checked++;
            if (pending_words.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("ERROR: unexpected response %h %h %h %h at %0t",
                           got[0], got[1], got[2], got[3], $realtime);
            end else begin
               want = pending_words.pop_front();
               bad  = 1'b0;
               for (int i = 0; i < NF; i++)
                  if (got[i] !== want[i]) bad = 1'b1;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"ERROR: dir %0d dims %0d bits %0d: ",
                               "expected %h %h %h %h, got %h %h %h %h"},
                              dir_sel, dims_reg, bits_reg,
                              want[0], want[1], want[2], want[3],
                              got[0], got[1], got[2], got[3]);
               end
            end
         end
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (rx_gaps && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (idle_length()) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Ends the run if no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_point(input point_type coords);
      req_valid   <= 1'b1;
      req_coord_0 <= coords[0];
      req_coord_1 <= coords[1];
      req_coord_2 <= coords[2];
      req_coord_3 <= coords[3];
      do @(posedge clock); while (!req_ready);
      points_sent++;
      if (tx_gaps && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
   endtask

   // The first edge lets the scoreboard record a transaction accepted at
   // the edge on which the caller resumed.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only once the pipeline has emptied.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_writes++;
      if (index == hat_pkg::REG_DIRECTION) dir_sel = value[0];
      else if (index == hat_pkg::REG_DIMS_IN_USE) dims_reg = value[hat_pkg::DIMS_W-1:0];
      else if (index == hat_pkg::REG_BITS_IN_USE) bits_reg = value[hat_pkg::BITS_W-1:0];
   endtask

   task automatic set_mode(input logic [31:0] dir, input logic [31:0] dims,
                           input logic [31:0] bits);
      write_register(hat_pkg::REG_DIRECTION, dir);
      write_register(hat_pkg::REG_DIMS_IN_USE, dims);
      write_register(hat_pkg::REG_BITS_IN_USE, bits);
   endtask

   task automatic test_reset_defaults();
      send_point('0);
      send_point({4{16'hFFFF}});
      send_point({16'h1234, 16'h8000, 16'h0001, 16'h8000});
      send_point({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
      send_point({16'hA5A5, 16'h5A5A, 16'hAAAA, 16'h5555});
   endtask

   task automatic test_directed_corners();
      // Four dimensions, full width, reverse direction.
      set_mode(32'(hat_pkg::DIR_TO_AXES), 4, 16);
      send_point('0);
      send_point({4{16'hFFFF}});
      send_point({16'h0001, 16'h8000, 16'h7FFF, 16'h8001});
      // Zero counts act as one dimension of one bit.
      set_mode(32'(hat_pkg::DIR_TO_TRANSPOSE), 0, 0);
      send_point({4{16'hFFFF}});
      send_point({16'h0000, 16'h0000, 16'h0000, 16'h0001});
      // Oversized counts saturate.
      set_mode(32'(hat_pkg::DIR_TO_AXES), 7, 31);
      send_point({4{16'hFFFF}});
      send_point({16'h8000, 16'h4000, 16'h0002, 16'h0001});
      set_mode(32'(hat_pkg::DIR_TO_TRANSPOSE), 4, 17);
      send_point({16'hC3C3, 16'h0F0F, 16'hFFFF, 16'h0001});
      // Single bit and two dimensions, excess bits must be ignored.
      set_mode(32'(hat_pkg::DIR_TO_AXES), 2, 1);
      send_point({4{16'hFFFF}});
      send_point({16'h0001, 16'h0001, 16'hFFFE, 16'h0001});
      set_mode(32'(hat_pkg::DIR_TO_TRANSPOSE), 1, 1);
      send_point({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE});
      // A write to an unmapped index must change nothing.
      write_register(CSR_SPARE_INDEX, 32'hFFFF_FFFF);
      send_point({16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
   endtask

   task automatic test_random_settings(input int phases, input int per_phase);
      logic [31:0] dims, bits, junk;
      for (int ph = 0; ph < phases; ph++) begin
         dims = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
         bits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
         junk = $urandom();
         // Upper bus bits carry junk; only the register width is stored.
         set_mode({junk[31:1], 1'($urandom_range(0, 1))}, {junk[31:3], dims[2:0]},
                  {junk[31:5], bits[4:0]});
         tx_gaps = (ph % 3 != 0);
         rx_gaps = (ph % 3 != 1);
         for (int k = 0; k < per_phase; k++)
            send_point({16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())});
      end
   endtask

   task automatic test_backpressure();
      set_mode(32'(hat_pkg::DIR_TO_AXES), 4, 16);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      hold_request = 1'b1;
      for (int k = 0; k < 60; k++)
         send_point({16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())});
      rx_gaps = 1'b1;
      tx_gaps = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_corners();
      test_random_settings(8, 40);
      test_backpressure();
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d points over %0d register writes, including saturated and zero counts,",
               points_sent, csr_writes);
      $display("both directions and a long response stall; %0d responses checked, %0d bad.",
               results_checked, mismatches);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
